// ===== rtl/core/rau_pkg.sv =====
// Shared types, constants and the sequencer microcode for the rational arithmetic unit.
// Used by every module of the block; depends on nothing else.
package rau_pkg;

   localparam int WIDTH  = 32;
   localparam int DW     = 2 * WIDTH;
   localparam int CNT_W  = $clog2(DW + 1);
   localparam int K_W    = $clog2(WIDTH);
   localparam int STEP_W = 5;

   typedef enum logic [1:0] {
      KIND_ADD = 2'd0,
      KIND_SUB = 2'd1,
      KIND_MUL = 2'd2,
      KIND_DIV = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK   = 2'd0,
      ST_ZDEN = 2'd1,
      ST_DIVZ = 2'd2,
      ST_OVF  = 2'd3
   } status_code_type;

   typedef enum logic [3:0] {
      OP_GCD  = 4'd0,
      OP_DIVS = 4'd1,
      OP_DIVL = 4'd2,
      OP_REM  = 4'd3,
      OP_MUL  = 4'd4,
      OP_FIXA = 4'd5,
      OP_FIXB = 4'd6,
      OP_COMB = 4'd7,
      OP_CHKZ = 4'd8,
      OP_END  = 4'd9
   } op_type;

   typedef enum logic [3:0] {
      SEL_AN = 4'd0,
      SEL_AD = 4'd1,
      SEL_BN = 4'd2,
      SEL_BD = 4'd3,
      SEL_G  = 4'd4,
      SEL_H  = 4'd5,
      SEL_P  = 4'd6,
      SEL_Q  = 4'd7,
      SEL_WX = 4'd8,
      SEL_WY = 4'd9
   } sel_type;

   typedef struct packed {
      op_type  op;
      sel_type sa;
      sel_type sb;
      sel_type dst;
   } uop_type;

   typedef struct packed {
      logic    load;
      logic    start;
      logic    step_en;
      logic    out_load;
      uop_type uop;
   } ctrl_type;

   typedef struct packed {
      logic unit_done;
      logic early_exit;
      logic addsub;
   } dp_status_type;

   function automatic uop_type mk(input op_type op, input sel_type sa, input sel_type sb,
                                  input sel_type dst);
      uop_type u;
      u.op  = op;
      u.sa  = sa;
      u.sb  = sb;
      u.dst = dst;
      return u;
   endfunction

   // Add and subtract: scale over the lcm, then reduce the sum.
   function automatic uop_type tail_addsub(input logic [STEP_W-1:0] idx);
      uop_type u;
      case (idx)
         5'd8:    u = mk(OP_GCD,  SEL_AD, SEL_BD, SEL_G);
         5'd9:    u = mk(OP_DIVS, SEL_AD, SEL_G,  SEL_P);
         5'd10:   u = mk(OP_DIVS, SEL_BD, SEL_G,  SEL_Q);
         5'd11:   u = mk(OP_MUL,  SEL_AN, SEL_Q,  SEL_WX);
         5'd12:   u = mk(OP_MUL,  SEL_BN, SEL_P,  SEL_WY);
         5'd13:   u = mk(OP_COMB, SEL_AN, SEL_AN, SEL_WX);
         5'd14:   u = mk(OP_REM,  SEL_AN, SEL_G,  SEL_H);
         5'd15:   u = mk(OP_GCD,  SEL_G,  SEL_H,  SEL_H);
         5'd16:   u = mk(OP_DIVL, SEL_AN, SEL_H,  SEL_WX);
         5'd17:   u = mk(OP_DIVS, SEL_BD, SEL_H,  SEL_Q);
         5'd18:   u = mk(OP_MUL,  SEL_P,  SEL_Q,  SEL_WY);
         default: u = mk(OP_END,  SEL_AN, SEL_AN, SEL_AN);
      endcase
      return u;
   endfunction

   // Multiply and divide: check for a zero numerator, cross-reduce, then two products.
   function automatic uop_type tail_muldiv(input logic [STEP_W-1:0] idx);
      uop_type u;
      case (idx)
         5'd8:    u = mk(OP_CHKZ, SEL_AN, SEL_AN, SEL_AN);
         5'd9:    u = mk(OP_GCD,  SEL_AN, SEL_BD, SEL_G);
         5'd10:   u = mk(OP_GCD,  SEL_BN, SEL_AD, SEL_H);
         5'd11:   u = mk(OP_DIVS, SEL_AN, SEL_G,  SEL_AN);
         5'd12:   u = mk(OP_DIVS, SEL_BD, SEL_G,  SEL_BD);
         5'd13:   u = mk(OP_DIVS, SEL_BN, SEL_H,  SEL_BN);
         5'd14:   u = mk(OP_DIVS, SEL_AD, SEL_H,  SEL_AD);
         5'd15:   u = mk(OP_MUL,  SEL_AN, SEL_BN, SEL_WX);
         5'd16:   u = mk(OP_MUL,  SEL_AD, SEL_BD, SEL_WY);
         default: u = mk(OP_END,  SEL_AN, SEL_AN, SEL_AN);
      endcase
      return u;
   endfunction

   // Common prefix normalizes both operands.
   function automatic uop_type rau_ucode(input logic addsub, input logic [STEP_W-1:0] idx);
      uop_type u;
      case (idx)
         5'd0:    u = mk(OP_GCD,  SEL_AN, SEL_AD, SEL_G);
         5'd1:    u = mk(OP_DIVS, SEL_AN, SEL_G,  SEL_AN);
         5'd2:    u = mk(OP_DIVS, SEL_AD, SEL_G,  SEL_AD);
         5'd3:    u = mk(OP_FIXA, SEL_AN, SEL_AN, SEL_AN);
         5'd4:    u = mk(OP_GCD,  SEL_BN, SEL_BD, SEL_G);
         5'd5:    u = mk(OP_DIVS, SEL_BN, SEL_G,  SEL_BN);
         5'd6:    u = mk(OP_DIVS, SEL_BD, SEL_G,  SEL_BD);
         5'd7:    u = mk(OP_FIXB, SEL_AN, SEL_AN, SEL_AN);
         default: u = addsub ? tail_addsub(idx) : tail_muldiv(idx);
      endcase
      return u;
   endfunction

endpackage

// ===== rtl/core/rau_gcd.sv =====
// Binary gcd engine: one shift or subtract per cycle.
// Depends on rau_pkg.
module rau_gcd
   import rau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] x,
   input  logic [WIDTH-1:0] y,
   output logic             done,
   output logic [WIDTH-1:0] g
);

   logic [WIDTH-1:0] u_ff, v_ff, g_ff;
   logic [K_W-1:0]   k_ff;
   logic             busy_ff, done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && (u_ff == '0 || v_ff == '0)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         u_ff <= x;
         v_ff <= y;
         k_ff <= '0;
      end else if (busy_ff) begin
         if (u_ff == '0 || v_ff == '0) begin
            // When both are zero the gcd is taken as one.
            g_ff <= (u_ff == '0 && v_ff == '0) ? WIDTH'(1) : ((u_ff | v_ff) << k_ff);
         end else if (!u_ff[0] && !v_ff[0]) begin
            u_ff <= u_ff >> 1;
            v_ff <= v_ff >> 1;
            k_ff <= k_ff + 1'b1;
         end else if (!u_ff[0]) begin
            u_ff <= u_ff >> 1;
         end else if (!v_ff[0]) begin
            v_ff <= v_ff >> 1;
         end else if (u_ff >= v_ff) begin
            u_ff <= u_ff - v_ff;
         end else begin
            v_ff <= v_ff - u_ff;
         end
      end
   end

   assign done = done_ff;
   assign g    = g_ff;

endmodule

// ===== rtl/core/rau_div.sv =====
// Restoring divider, one quotient bit per cycle, single or double width dividend.
// Depends on rau_pkg.
module rau_div
   import rau_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             short_div,
   input  logic [DW-1:0]    dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [DW-1:0]    quotient,
   output logic [WIDTH-1:0] remainder
);

   logic [DW-1:0]    quo_ff;
   logic [WIDTH-1:0] rem_ff, den_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff, done_ff;
   logic [WIDTH:0]   rem_sh, rem_diff;
   logic             fits;

   assign rem_sh   = {rem_ff, quo_ff[DW-1]};
   assign fits     = rem_sh >= {1'b0, den_ff};
   assign rem_diff = rem_sh - {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= busy_ff && cnt_ff == CNT_W'(1);
         if (start) begin
            busy_ff <= 1'b1;
         end else if (busy_ff && cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         // A single width dividend skips the all-zero upper half.
         quo_ff <= short_div ? {dividend[WIDTH-1:0], {WIDTH{1'b0}}} : dividend;
         rem_ff <= '0;
         den_ff <= divisor;
         cnt_ff <= short_div ? CNT_W'(WIDTH) : CNT_W'(DW);
      end else if (busy_ff) begin
         rem_ff <= fits ? rem_diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
         quo_ff <= {quo_ff[DW-2:0], fits};
         cnt_ff <= cnt_ff - 1'b1;
      end
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/core/rau_datapath.sv =====
// Datapath: operand registers, gcd engine, divider, multiplier and the result register.
// Depends on rau_pkg, rau_gcd and rau_div.
module rau_datapath
   import rau_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  ctrl_type                ctrl,
   output dp_status_type           st,
   input  logic [1:0]              req_kind,
   input  logic signed [WIDTH-1:0] req_a_num,
   input  logic signed [WIDTH-1:0] req_a_den,
   input  logic signed [WIDTH-1:0] req_b_num,
   input  logic signed [WIDTH-1:0] req_b_den,
   output logic signed [WIDTH-1:0] rsp_result_num,
   output logic [WIDTH-2:0]        rsp_result_den,
   output logic [1:0]              rsp_status
);

   function automatic logic [WIDTH-1:0] mag_of(input logic [WIDTH-1:0] v);
      return v[WIDTH-1] ? (~v + 1'b1) : v;
   endfunction

   logic [WIDTH-1:0] an_ff, ad_ff, bn_ff, bd_ff, g_ff, h_ff, p_ff, q_ff;
   logic [DW-1:0]    wx_ff, wy_ff;
   logic [3:0]       sg_ff;
   kind_type         kind_ff;
   status_code_type  err_ff;
   logic             zero_ff, as_ff, bs_ff, rs_ff;

   logic [WIDTH-1:0] opa, opb, wr_val, gcd_g, div_rem;
   logic [DW-1:0]    div_quo, prod, t_val;
   logic             gcd_done, div_done, wr_en, t_rs, bs0;
   sel_type          wr_dst;
   op_type           op;
   logic [WIDTH-1:0] a_dm, b_nm, b_dm;
   status_code_type  err_in;

   logic signed [WIDTH-1:0] res_num_in;
   logic [WIDTH-2:0]        res_den_in;
   status_code_type         res_st_in;
   logic                    ovf;

   assign op = ctrl.uop.op;

   always_comb begin
      case (ctrl.uop.sa)
         SEL_AN:  opa = an_ff;
         SEL_AD:  opa = ad_ff;
         SEL_BN:  opa = bn_ff;
         SEL_BD:  opa = bd_ff;
         SEL_G:   opa = g_ff;
         SEL_H:   opa = h_ff;
         SEL_P:   opa = p_ff;
         SEL_Q:   opa = q_ff;
         default: opa = '0;
      endcase
      case (ctrl.uop.sb)
         SEL_AN:  opb = an_ff;
         SEL_AD:  opb = ad_ff;
         SEL_BN:  opb = bn_ff;
         SEL_BD:  opb = bd_ff;
         SEL_G:   opb = g_ff;
         SEL_H:   opb = h_ff;
         SEL_P:   opb = p_ff;
         SEL_Q:   opb = q_ff;
         default: opb = '0;
      endcase
   end

   rau_gcd u_gcd (
      .clock (clock),
      .reset (reset),
      .start (ctrl.start && op == OP_GCD),
      .x     (opa),
      .y     (opb),
      .done  (gcd_done),
      .g     (gcd_g)
   );

   rau_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctrl.start && (op == OP_DIVS || op == OP_DIVL || op == OP_REM)),
      .short_div (op == OP_DIVS),
      .dividend  ((op == OP_DIVS) ? {{WIDTH{1'b0}}, opa} : wx_ff),
      .divisor   (opb),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   assign prod = opa * opb;

   // Signed sum of the two scaled numerators, kept as sign and magnitude.
   always_comb begin
      if (as_ff == bs_ff) begin
         t_val = wx_ff + wy_ff;
         t_rs  = as_ff;
      end else if (wx_ff >= wy_ff) begin
         t_val = wx_ff - wy_ff;
         t_rs  = as_ff;
      end else begin
         t_val = wy_ff - wx_ff;
         t_rs  = bs_ff;
      end
   end

   always_comb begin
      wr_en  = st.unit_done && (op == OP_GCD || op == OP_DIVS || op == OP_REM);
      wr_dst = (op == OP_REM) ? SEL_H : ctrl.uop.dst;
      case (op)
         OP_GCD:  wr_val = gcd_g;
         OP_DIVS: wr_val = div_quo[WIDTH-1:0];
         default: wr_val = div_rem;
      endcase
   end

   assign a_dm = mag_of(req_a_den);
   assign b_nm = mag_of(req_b_num);
   assign b_dm = mag_of(req_b_den);

   always_comb begin
      if (a_dm == '0 || b_dm == '0) begin
         err_in = ST_ZDEN;
      end else if (kind_type'(req_kind) == KIND_DIV && b_nm == '0) begin
         err_in = ST_DIVZ;
      end else begin
         err_in = ST_OK;
      end
   end

   assign bs0 = (sg_ff[2] ^ sg_ff[3]) && bn_ff != '0;

   // Operand and intermediate registers.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         an_ff <= mag_of(req_a_num);
         ad_ff <= a_dm;
         bn_ff <= b_nm;
         bd_ff <= b_dm;
         sg_ff <= {req_b_den[WIDTH-1], req_b_num[WIDTH-1], req_a_den[WIDTH-1],
                   req_a_num[WIDTH-1]};
      end else if (wr_en) begin
         case (wr_dst)
            SEL_AN:  an_ff <= wr_val;
            SEL_AD:  ad_ff <= wr_val;
            SEL_BN:  bn_ff <= wr_val;
            SEL_BD:  bd_ff <= wr_val;
            SEL_G:   g_ff  <= wr_val;
            SEL_H:   h_ff  <= wr_val;
            SEL_P:   p_ff  <= wr_val;
            SEL_Q:   q_ff  <= wr_val;
            default: ;
         endcase
      end else if (st.unit_done && op == OP_DIVL) begin
         wx_ff <= div_quo;
      end else if (ctrl.step_en) begin
         case (op)
            OP_FIXA: begin
               if (an_ff == '0) ad_ff <= WIDTH'(1);
            end
            OP_FIXB: begin
               // Divide multiplies by the reciprocal of the second operand.
               if (kind_ff == KIND_DIV) begin
                  bn_ff <= bd_ff;
                  bd_ff <= bn_ff;
               end else if (bn_ff == '0) begin
                  bd_ff <= WIDTH'(1);
               end
            end
            OP_MUL: begin
               if (ctrl.uop.dst == SEL_WX) wx_ff <= prod;
               else wy_ff <= prod;
            end
            OP_COMB: wx_ff <= t_val;
            default: ;
         endcase
      end
   end

   // Signs, error code and the early-exit flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         err_ff  <= ST_OK;
         zero_ff <= 1'b0;
         as_ff   <= 1'b0;
         bs_ff   <= 1'b0;
         rs_ff   <= 1'b0;
         kind_ff <= KIND_ADD;
      end else if (ctrl.load) begin
         err_ff  <= err_in;
         zero_ff <= 1'b0;
         kind_ff <= kind_type'(req_kind);
      end else if (ctrl.step_en) begin
         case (op)
            OP_FIXA: as_ff <= (sg_ff[0] ^ sg_ff[1]) && an_ff != '0;
            OP_FIXB: bs_ff <= (kind_ff == KIND_SUB) ? (!bs0 && bn_ff != '0) : bs0;
            OP_CHKZ: begin
               zero_ff <= an_ff == '0 || bn_ff == '0;
               rs_ff   <= as_ff ^ bs_ff;
            end
            OP_COMB: begin
               zero_ff <= t_val == '0;
               rs_ff   <= t_rs;
            end
            default: ;
         endcase
      end
   end

   assign st.unit_done  = gcd_done || div_done;
   assign st.early_exit = err_ff != ST_OK || zero_ff;
   assign st.addsub     = kind_ff == KIND_ADD || kind_ff == KIND_SUB;

   assign ovf = wx_ff[DW-1:WIDTH-1] != '0 || wy_ff[DW-1:WIDTH-1] != '0;

   always_comb begin
      res_num_in = '0;
      res_den_in = '0;
      res_st_in  = ST_OK;
      if (err_ff != ST_OK) begin
         res_st_in = err_ff;
      end else if (zero_ff) begin
         res_den_in = (WIDTH-1)'(1);
      end else if (ovf) begin
         res_st_in = ST_OVF;
      end else begin
         res_num_in = rs_ff ? (~wx_ff[WIDTH-1:0] + 1'b1) : wx_ff[WIDTH-1:0];
         res_den_in = wy_ff[WIDTH-2:0];
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.out_load) begin
         rsp_result_num <= res_num_in;
         rsp_result_den <= res_den_in;
         rsp_status     <= res_st_in;
      end
   end

endmodule

// ===== rtl/core/rau_ctrl.sv =====
// Controller: state machine and microcode step counter driving the datapath.
// Depends on rau_pkg.
module rau_ctrl
   import rau_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   input  dp_status_type st,
   output ctrl_type      ctrl
);

   typedef enum logic [3:0] {
      S_IDLE = 4'b0001,
      S_RUN  = 4'b0010,
      S_WAIT = 4'b0100,
      S_OUT  = 4'b1000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   uop_type           uop;
   logic              slot_free;

   assign uop       = rau_ucode(st.addsub, idx_ff);
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      idx_in        = idx_ff;
      ctrl.load     = 1'b0;
      ctrl.start    = 1'b0;
      ctrl.step_en  = 1'b0;
      ctrl.out_load = 1'b0;
      ctrl.uop      = uop;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               ctrl.load = 1'b1;
               idx_in    = '0;
               state_in  = S_RUN;
            end
         end
         S_RUN: begin
            if (st.early_exit || uop.op == OP_END) begin
               state_in = S_OUT;
            end else if (uop.op == OP_GCD || uop.op == OP_DIVS || uop.op == OP_DIVL ||
                         uop.op == OP_REM) begin
               ctrl.start = 1'b1;
               state_in   = S_WAIT;
            end else begin
               ctrl.step_en = 1'b1;
               idx_in       = idx_ff + 1'b1;
            end
         end
         S_WAIT: begin
            if (st.unit_done) begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_RUN;
            end
         end
         S_OUT: begin
            if (slot_free) begin
               ctrl.out_load = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      if (ctrl.out_load) rsp_valid_in = 1'b1;
      else if (!rsp_stall) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

   a_done_only_waiting: assert property (@(posedge clock) disable iff (reset)
      st.unit_done |-> state_ff == S_WAIT)
      else $error("arithmetic unit finished outside a wait");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      ctrl.out_load |-> !(rsp_valid_ff && rsp_stall))
      else $error("result register overwritten while stalled");

   a_start_waits: assert property (@(posedge clock) disable iff (reset)
      ctrl.start |=> state_ff == S_WAIT)
      else $error("unit started without waiting for it");

   a_accept_runs: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> state_ff == S_RUN && idx_ff == '0)
      else $error("accepted transfer did not start the sequence");

endmodule

// ===== rtl/core/rational_arithmetic_unit.sv =====
// Rational arithmetic unit: exact add, subtract, multiply, divide of two fractions.
// An item ends early on a zero denominator, a divide by zero or a zero result; otherwise
// its run time is set by the binary gcd engine and the bit-serial divider, each started
// by the controller, which then waits in its own state for the unit to finish.
// Throughput: one item at a time; the next request is taken once the result is in the
// output register. Synchronous active-high reset idles the controller and clears rsp_valid.
module rational_arithmetic_unit
   import rau_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [1:0]              req_kind,
   input  logic signed [WIDTH-1:0] req_a_num,
   input  logic signed [WIDTH-1:0] req_a_den,
   input  logic signed [WIDTH-1:0] req_b_num,
   input  logic signed [WIDTH-1:0] req_b_den,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WIDTH-1:0] rsp_result_num,
   output logic [WIDTH-2:0]        rsp_result_den,
   output logic [1:0]              rsp_status
);

   // The controller walks a short microcode program: both operands are first
   // reduced by their gcd, then either scaled over the lcm of the denominators
   // (add and subtract) or cross-reduced (multiply and divide). Errors found at
   // the input transfer, and a zero result, skip the rest of the program.
   ctrl_type      ctrl;
   dp_status_type st;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .st        (st),
      .ctrl      (ctrl)
   );

   // The datapath holds all operands, the gcd engine, the divider and the
   // output register, which lets a finished result wait for its transfer.
   rau_datapath u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctrl           (ctrl),
      .st             (st),
      .req_kind       (req_kind),
      .req_a_num      (req_a_num),
      .req_a_den      (req_a_den),
      .req_b_num      (req_b_num),
      .req_b_den      (req_b_den),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den),
      .rsp_status     (rsp_status)
   );

endmodule
